### design/rate_limited_pose_window_average_core_assert.svh
// Assertion helpers for the pose window averager.
// Each macro expects clk and rst_n in scope.
`ifndef RATE_LIMITED_POSE_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define RATE_LIMITED_POSE_WINDOW_AVERAGE_CORE_ASSERT_SVH

// Consequent checked in the same cycle.
`define RLPWA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpwa: same-cycle check failed");

// Consequent checked in the next cycle.
`define RLPWA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpwa: next-cycle check failed");

`endif

### design/rlpwa_pkg.sv
package rlpwa_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int WP_W       = $clog2(WINDOW_MAX);
    localparam int HELD_W     = $clog2(WINDOW_MAX + 1);

    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int WLEN_W     = 7;
    localparam int POS_W      = 32;
    localparam int ORI_W      = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_PERIOD = 1'b1;

    localparam logic [WLEN_W-1:0]   WLEN_RESET   = 7'd4;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;

    localparam int POS_LANES = 3;
    localparam int ORI_LANES = 4;
    localparam int NUM_LANES = POS_LANES + ORI_LANES;

    // accumulator width: one full window of position words
    localparam int SUM_W = POS_W + $clog2(WINDOW_MAX);
    // shared counter: window index during summing, bit index during divide
    localparam int CNT_W = (WINDOW_MAX > SUM_W) ? $clog2(WINDOW_MAX) : $clog2(SUM_W);

    typedef struct packed {
        logic [ORI_LANES-1:0][ORI_W-1:0] ori;
        logic [POS_LANES-1:0][POS_W-1:0] pos;
    } sample_t;

    typedef struct packed {
        logic accept;
        logic cnt_clr;
        logic cnt_inc;
        logic rd;
        logic acc;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic cnt_zero;
        logic sum_last;
        logic div_last;
    } status_t;

endpackage

### design/rlpwa_ctrl.sv
module rlpwa_ctrl
    import rlpwa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PREP  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    if (status.hit)
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                // read data is registered, so it arrives in the cycle after its address
                cmd.rd  = 1'b1;
                cmd.acc = !status.cnt_zero;
                if (status.sum_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_DRAIN;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_DRAIN:
            begin
                cmd.acc    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/rlpwa_datapath.sv
module rlpwa_datapath
    import rlpwa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic        [TIME_W-1:0]    now_sec,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic signed [ORI_W-1:0]     ori_w,
    input  logic signed [ORI_W-1:0]     ori_x,
    input  logic signed [ORI_W-1:0]     ori_y,
    input  logic signed [ORI_W-1:0]     ori_z,
    input  cmd_t                        cmd,
    output status_t                     status,
    output logic        [TIME_W-1:0]    stamp_sec,
    output logic signed [POS_W-1:0]     avg_pos_x,
    output logic signed [POS_W-1:0]     avg_pos_y,
    output logic signed [POS_W-1:0]     avg_pos_z,
    output logic signed [ORI_W-1:0]     avg_ori_w,
    output logic signed [ORI_W-1:0]     avg_ori_x,
    output logic signed [ORI_W-1:0]     avg_ori_y,
    output logic signed [ORI_W-1:0]     avg_ori_z
);

    // control state
    logic [WLEN_W-1:0]   wlen_reg,   wlen_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [WP_W-1:0]     wp_reg,     wp_next;
    logic [HELD_W-1:0]   held_reg,   held_next;
    logic [TIME_W-1:0]   last_reg,   last_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;

    // payload
    sample_t             store_reg [WINDOW_MAX];
    sample_t             rd_data_reg;
    logic [WLEN_W-1:0]   n_reg;
    logic [TIME_W-1:0]   stamp_reg;
    logic [SUM_W-1:0]    acc_reg [NUM_LANES];
    logic [SUM_W-1:0]    quo_reg [NUM_LANES];
    logic [WLEN_W-1:0]   rem_reg [NUM_LANES];
    logic                neg_reg [NUM_LANES];
    logic [TIME_W-1:0]   out_stamp_reg;
    logic [POS_W-1:0]    out_pos_reg [POS_LANES];
    logic [ORI_W-1:0]    out_ori_reg [ORI_LANES];

    sample_t             wr_sample;
    logic [TIME_W:0]     deadline;
    logic                time_ok;
    logic [HELD_W-1:0]   held_inc;
    logic [WLEN_W-1:0]   n_eff;
    logic [WP_W:0]       addr_sum;
    logic [WP_W-1:0]     rd_addr;
    logic [SUM_W-1:0]    rd_ext   [NUM_LANES];
    logic [SUM_W-1:0]    acc_mag  [NUM_LANES];
    logic [WLEN_W:0]     trial    [NUM_LANES];
    logic                ge       [NUM_LANES];
    logic [WLEN_W-1:0]   rem_step [NUM_LANES];
    logic [SUM_W-1:0]    quo_res  [NUM_LANES];

    assign wr_sample.pos = {pos_z, pos_y, pos_x};
    assign wr_sample.ori = {ori_z, ori_y, ori_x, ori_w};

    // publish decision, evaluated on the incoming word
    assign deadline = {1'b0, last_reg} + (TIME_W + 1)'(period_reg);
    assign time_ok  = {1'b0, now_sec} > deadline;
    assign held_inc = (held_reg == HELD_W'(WINDOW_MAX)) ? held_reg : held_reg + HELD_W'(1);
    assign n_eff    = (wlen_reg == '0) ? WLEN_W'(1) : wlen_reg;

    assign status.hit      = time_ok && (32'(held_inc) >= 32'(n_eff));
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.sum_last = (cnt_reg == CNT_W'(n_reg - WLEN_W'(1)));
    assign status.div_last = (cnt_reg == CNT_W'(SUM_W - 1));

    // newest-first walk: wp - 1 - cnt, modulo the store depth
    assign addr_sum = (WP_W + 1)'(wp_reg) + (WP_W + 1)'(WINDOW_MAX - 1) - (WP_W + 1)'(cnt_reg);
    assign rd_addr  = (addr_sum >= (WP_W + 1)'(WINDOW_MAX))
                    ? WP_W'(addr_sum - (WP_W + 1)'(WINDOW_MAX))
                    : WP_W'(addr_sum);

    always_comb
    begin
        for (int l = 0; l < POS_LANES; l++)
        begin
            rd_ext[l] = SUM_W'($signed(rd_data_reg.pos[l]));
        end
        for (int l = 0; l < ORI_LANES; l++)
        begin
            rd_ext[POS_LANES + l] = SUM_W'($signed(rd_data_reg.ori[l]));
        end
        for (int l = 0; l < NUM_LANES; l++)
        begin
            acc_mag[l]  = acc_reg[l][SUM_W-1] ? (~acc_reg[l] + SUM_W'(1)) : acc_reg[l];
            // restoring divide, one quotient bit per step
            trial[l]    = {rem_reg[l], quo_reg[l][SUM_W-1]};
            ge[l]       = (trial[l] >= {1'b0, n_reg});
            rem_step[l] = ge[l] ? WLEN_W'(trial[l] - {1'b0, n_reg}) : WLEN_W'(trial[l]);
            quo_res[l]  = neg_reg[l] ? (~quo_reg[l] + SUM_W'(1)) : quo_reg[l];
        end
    end

    always_comb
    begin
        wlen_next   = wlen_reg;
        period_next = period_reg;
        wp_next     = wp_reg;
        held_next   = held_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LEN:     wlen_next   = cfg_wdata[WLEN_W-1:0];
                REG_PUBLISH_PERIOD: period_next = cfg_wdata[PERIOD_W-1:0];
                default:            ;
            endcase
        end

        if (cmd.accept)
        begin
            wp_next = (wp_reg == WP_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + WP_W'(1);
            if (status.hit)
            begin
                held_next = '0;
                last_next = now_sec;
            end
            else
            begin
                held_next = held_inc;
            end
        end

        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= WLEN_RESET;
            period_reg <= PERIOD_RESET;
            wp_reg     <= '0;
            held_reg   <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wlen_reg   <= wlen_next;
            period_reg <= period_next;
            wp_reg     <= wp_next;
            held_reg   <= held_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
        end
    end

    // sample store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_reg[wp_reg] <= wr_sample;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n_reg     <= n_eff;
            stamp_reg <= now_sec;
        end
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (cmd.accept)
            begin
                acc_reg[l] <= '0;
            end
            else if (cmd.acc)
            begin
                acc_reg[l] <= acc_reg[l] + rd_ext[l];
            end

            if (cmd.div_load)
            begin
                quo_reg[l] <= acc_mag[l];
                rem_reg[l] <= '0;
                neg_reg[l] <= acc_reg[l][SUM_W-1];
            end
            else if (cmd.div_step)
            begin
                quo_reg[l] <= {quo_reg[l][SUM_W-2:0], ge[l]};
                rem_reg[l] <= rem_step[l];
            end
        end
        if (cmd.out_load)
        begin
            out_stamp_reg <= stamp_reg;
            for (int l = 0; l < POS_LANES; l++)
            begin
                out_pos_reg[l] <= quo_res[l][POS_W-1:0];
            end
            for (int l = 0; l < ORI_LANES; l++)
            begin
                out_ori_reg[l] <= quo_res[POS_LANES + l][ORI_W-1:0];
            end
        end
    end

    assign stamp_sec = out_stamp_reg;
    assign avg_pos_x = out_pos_reg[0];
    assign avg_pos_y = out_pos_reg[1];
    assign avg_pos_z = out_pos_reg[2];
    assign avg_ori_w = out_ori_reg[0];
    assign avg_ori_x = out_ori_reg[1];
    assign avg_ori_y = out_ori_reg[2];
    assign avg_ori_z = out_ori_reg[3];

endmodule

### design/rate_limited_pose_window_average_core.sv
// Pose window averager with a publish rate limit.
// Input channel (in_valid/in_ready): one word is a pose sample with its time
// in seconds. Every accepted word goes into a 64-entry ring store; the held
// count saturates at 64. When the time is past last publish + publish_period
// and at least window_len samples are held, the newest window_len samples are
// averaged per component (truncated toward zero) and one output word is sent.
// Output channel (out_valid/out_ready): stamp plus seven averages, held in an
// output register until taken. Config: cfg_we/cfg_index/cfg_wdata, index 0 =
// window_len, index 1 = publish_period; write only while idle.
// Flow: a word that publishes nothing leaves the core idle, so words can
// stream back to back. A publishing word goes through the accept, then
// window_len reads of the store, a drain and a setup step, a 38-step
// restoring divide run in parallel on seven lanes, and the output load,
// which waits while the output register still holds an untaken word.
// A stalled receiver does not block input: the next word is taken while the
// result waits, and only a second result waits for the register to free up.
// Reset: count, write pointer and last publish time clear, window_len = 4,
// publish_period = 1. Store contents are not cleared.
`include "rate_limited_pose_window_average_core_assert.svh"

module rate_limited_pose_window_average_core
    import rlpwa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic        [TIME_W-1:0]    now_sec,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic signed [ORI_W-1:0]     ori_w,
    input  logic signed [ORI_W-1:0]     ori_x,
    input  logic signed [ORI_W-1:0]     ori_y,
    input  logic signed [ORI_W-1:0]     ori_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic        [TIME_W-1:0]    stamp_sec,
    output logic signed [POS_W-1:0]     avg_pos_x,
    output logic signed [POS_W-1:0]     avg_pos_y,
    output logic signed [POS_W-1:0]     avg_pos_z,
    output logic signed [ORI_W-1:0]     avg_ori_w,
    output logic signed [ORI_W-1:0]     avg_ori_x,
    output logic signed [ORI_W-1:0]     avg_ori_y,
    output logic signed [ORI_W-1:0]     avg_ori_z
);

    cmd_t    cmd;
    status_t status;

    // sequencer: handshakes, store walk, divide steps, output load
    rlpwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // store, accumulators, divider lanes, output register
    rlpwa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .now_sec   (now_sec),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .ori_w     (ori_w),
        .ori_x     (ori_x),
        .ori_y     (ori_y),
        .ori_z     (ori_z),
        .cmd       (cmd),
        .status    (status),
        .stamp_sec (stamp_sec),
        .avg_pos_x (avg_pos_x),
        .avg_pos_y (avg_pos_y),
        .avg_pos_z (avg_pos_z),
        .avg_ori_w (avg_ori_w),
        .avg_ori_x (avg_ori_x),
        .avg_ori_y (avg_ori_y),
        .avg_ori_z (avg_ori_z)
    );

    // a word that does not publish leaves the input open
    `RLPWA_ASSERT_NEXT(a_no_hit_stays_ready, in_valid && in_ready && !status.hit, in_ready)
    // a publishing word closes the input until its result is loaded
    `RLPWA_ASSERT_NEXT(a_hit_blocks_input, in_valid && in_ready && status.hit, !in_ready)
    // output register is never overwritten while still holding a word
    `RLPWA_ASSERT_NOW(a_load_when_free, cmd.out_load, !out_valid || out_ready)
    // no store walk or divide step while waiting for input
    `RLPWA_ASSERT_NOW(a_idle_no_work, in_ready, !cmd.rd && !cmd.acc && !cmd.div_step)

endmodule
